### rtl/core/sai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_pkg: shared definitions for the sparse array table
// Field widths, status codes, register map and the table entry layout.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int KEY_W    = 57;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    localparam int CAPACITY_DEF = 32;

    localparam logic [KEY_W-1:0] MAX_INDEX_RESET = 57'd100000000000000000;

    // register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic [PADDR_W-1:0] ADDR_MAX_INDEX = 4'h0;

    // operation codes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

### rtl/core/sai_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_if: request and response channels of the sparse array table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sai_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [sai_pkg::KEY_W-1:0] index;
    logic [sai_pkg::VAL_W-1:0] write_value;

    modport source (output valid, output mode, output index, output write_value,
                    input ready);
    modport sink   (input valid, input mode, input index, input write_value,
                    output ready);
endinterface

interface sai_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sai_pkg::VAL_W-1:0]    read_value;
    logic [sai_pkg::STATUS_W-1:0] status;
    logic [sai_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output read_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input read_value, input status, input occupancy,
                    output ready);
endinterface

### rtl/core/sparse_array_assoc_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_array_assoc_table_unit: sparse array held as a packed key/value table
// Reads, updates, appends and deletes (index, value) pairs in one memory.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY (index, value) pairs packed at the bottom of
// one memory with one read and one write port and a registered read. Each item
// first scans the used slots, visiting each in a read state and then a compare
// state. A hit, or a miss over all used slots, goes on to a decide state that
// sets the result and then to a finish state that loads it into the output
// register. A delete first moves every later entry down one slot, a read state
// and a write state per entry moved, and then lowers the fill count. The block
// is ready again in the cycle after the result is loaded. A finished result
// sits in an output register, and the next item is taken while it waits; a
// result that finishes while the previous one is still unread holds until that
// one is taken. max_index is written over APB at byte address 0.
// ----------------------------------------------------------------------------
module sparse_array_assoc_table_unit #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sai_req_if.sink                     req,
    sai_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sai_pkg::PADDR_W-1:0] paddr,
    input  logic [sai_pkg::PDATA_W-1:0] pwdata,
    output logic [sai_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [sai_pkg::KEY_W-1:0] max_index_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             ptr_reg;
    logic [CW-1:0]             slot_reg;
    logic                      found_reg;
    logic [sai_pkg::VAL_W-1:0] found_val_reg;

    logic                      op_mode_reg;
    logic [sai_pkg::KEY_W-1:0] op_key_reg;
    logic [sai_pkg::VAL_W-1:0] op_val_reg;

    logic [sai_pkg::VAL_W-1:0]    res_value_reg;
    logic [sai_pkg::STATUS_W-1:0] res_status_reg;

    logic                         out_valid_reg;
    logic [sai_pkg::VAL_W-1:0]    out_value_reg;
    logic [sai_pkg::STATUS_W-1:0] out_status_reg;
    logic [sai_pkg::OCC_W-1:0]    out_occ_reg;

    sai_pkg::entry_t mem [CAPACITY];
    sai_pkg::entry_t rdata_reg;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    sai_pkg::entry_t mem_wdata;
    logic [IW-1:0]   mem_raddr;

    logic [CW-1:0] ptr_inc;
    logic          is_wr;
    logic          over_limit;
    logic          val_zero;
    logic          tbl_full;
    logic          key_hit;
    logic          out_free;
    logic          cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == sai_pkg::ADDR_MAX_INDEX);
    assign prdata = (paddr == sai_pkg::ADDR_MAX_INDEX)
                  ? sai_pkg::PDATA_W'(max_index_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_index_reg <= sai_pkg::MAX_INDEX_RESET;
        end
        else if (cfg_wr)
        begin
            max_index_reg <= pwdata[sai_pkg::KEY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // decode of the held item
    // ------------------------------------------------------------------
    assign ptr_inc    = ptr_reg + 1'b1;
    assign is_wr      = (op_mode_reg == sai_pkg::MODE_WRITE);
    assign over_limit = (op_key_reg > max_index_reg);
    assign val_zero   = (op_val_reg == '0);
    assign tbl_full   = (count_reg >= CAP_C);
    assign key_hit    = (rdata_reg.key == op_key_reg);
    assign out_free   = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // memory port control
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[IW-1:0];
        mem_wdata = rdata_reg;
        mem_raddr = ptr_reg[IW-1:0];
        unique case (state_reg)
            S_DECIDE:
            begin
                if (is_wr && !over_limit && !val_zero)
                begin
                    if (found_reg)
                    begin
                        // update in place
                        mem_we    = 1'b1;
                        mem_waddr = slot_reg[IW-1:0];
                    end
                    else if (!tbl_full)
                    begin
                        // append at the end
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[IW-1:0];
                    end
                end
                mem_wdata.key   = op_key_reg;
                mem_wdata.value = op_val_reg;
            end
            S_SH_RD:
            begin
                mem_raddr = ptr_inc[IW-1:0];
            end
            S_SH_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.occupancy  = out_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the finish state loads the output register itself
            if (rsp.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_mode_reg <= req.mode;
                        op_key_reg  <= req.index;
                        op_val_reg  <= req.write_value;
                        ptr_reg     <= '0;
                        state_reg   <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (ptr_reg < count_reg)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                end
                S_CMP:
                begin
                    if (key_hit)
                    begin
                        found_reg     <= 1'b1;
                        slot_reg      <= ptr_reg;
                        found_val_reg <= rdata_reg.value;
                        state_reg     <= S_DECIDE;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= S_SRCH;
                    end
                end
                S_DECIDE:
                begin
                    if (!is_wr || over_limit)
                    begin
                        // plain lookup or rejected write: state unchanged
                        res_value_reg  <= found_reg ? found_val_reg : '0;
                        res_status_reg <= over_limit && is_wr ? sai_pkg::STATUS_LIMIT
                                                              : sai_pkg::STATUS_OK;
                        state_reg      <= S_FINISH;
                    end
                    else if (val_zero)
                    begin
                        res_value_reg  <= '0;
                        res_status_reg <= sai_pkg::STATUS_OK;
                        if (found_reg)
                        begin
                            // remove: close the gap from the hit slot upward
                            ptr_reg   <= slot_reg;
                            state_reg <= S_SH_RD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else if (found_reg)
                    begin
                        res_value_reg  <= op_val_reg;
                        res_status_reg <= sai_pkg::STATUS_OK;
                        state_reg      <= S_FINISH;
                    end
                    else if (tbl_full)
                    begin
                        res_value_reg  <= '0;
                        res_status_reg <= sai_pkg::STATUS_FULL;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        res_value_reg  <= op_val_reg;
                        res_status_reg <= sai_pkg::STATUS_OK;
                        count_reg      <= count_reg + 1'b1;
                        state_reg      <= S_FINISH;
                    end
                end
                S_SH_RD:
                begin
                    if (ptr_inc < count_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FINISH;
                    end
                end
                S_SH_WR:
                begin
                    ptr_reg   <= ptr_inc;
                    state_reg <= S_SH_RD;
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        out_occ_reg    <= sai_pkg::OCC_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_C)
        else $error("table fill count above capacity");

    // memory writes stay within the used slots or the first free slot
    assert property (@(posedge clk) disable iff (!rst_n)
                     mem_we |-> (CW'(mem_waddr) <= count_reg))
        else $error("memory write beyond the used slots");

    // a full-table status is only reported with the table full
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_FINISH && res_status_reg == sai_pkg::STATUS_FULL)
                     |-> (count_reg == CAP_C))
        else $error("full status with free slots");

    // a delete leaves the fill count as it was when the shift begins
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_DECIDE && is_wr && !over_limit && val_zero && found_reg)
                     |=> (count_reg == $past(count_reg)))
        else $error("fill count changed before the shift finished");
`endif

endmodule

### tb/sv/sai_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_tb_pkg: scoreboard for the sparse array table testbench
// Keeps a private copy of the packed (index, value) table and the index
// limit, predicts each lookup result in order and compares the block's
// results field by field.
// ----------------------------------------------------------------------------
package sai_tb_pkg;

    import sai_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]    read_value;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } lookup_t;

    class sparse_table_scoreboard;

        logic [KEY_W-1:0] keys [CAPACITY_DEF];
        logic [VAL_W-1:0] vals [CAPACITY_DEF];
        int               count;
        logic [KEY_W-1:0] limit;

        lookup_t          expected_lookups [$];

        int mismatches;
        int results_seen;
        int n_reads;
        int n_deletes;
        int n_limit_rejects;
        int n_full_rejects;

        function new();
            count           = 0;
            limit           = MAX_INDEX_RESET;
            mismatches      = 0;
            results_seen    = 0;
            n_reads         = 0;
            n_deletes       = 0;
            n_limit_rejects = 0;
            n_full_rejects  = 0;
        endfunction

        function void set_limit(logic [KEY_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        // search only the slots in use
        function int slot_of(logic [KEY_W-1:0] key);
            for (int s = 0; s < count; s++)
            begin
                if (keys[s] == key)
                    return s;
            end
            return -1;
        endfunction

        function lookup_t apply_op(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            lookup_t r;
            int      slot;
            r.status = STATUS_OK;
            if (mode == MODE_WRITE)
            begin
                slot = slot_of(key);
                if (key > limit)
                begin
                    r.status = STATUS_LIMIT;
                end
                else if (val == '0)
                begin
                    if (slot >= 0)
                    begin
                        // close the gap left by the removed entry
                        for (int s = slot; s + 1 < count; s++)
                        begin
                            keys[s] = keys[s + 1];
                            vals[s] = vals[s + 1];
                        end
                        count--;
                        n_deletes++;
                    end
                end
                else if (slot >= 0)
                begin
                    vals[slot] = val;
                end
                else if (count >= CAPACITY_DEF)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    keys[count] = key;
                    vals[count] = val;
                    count++;
                end
            end
            else
            begin
                n_reads++;
            end
            if (r.status == STATUS_LIMIT)
                n_limit_rejects++;
            if (r.status == STATUS_FULL)
                n_full_rejects++;
            slot         = slot_of(key);
            r.read_value = (slot >= 0) ? vals[slot] : '0;
            r.occupancy  = OCC_W'(count);
            return r;
        endfunction

        function void note_request(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            expected_lookups.push_back(apply_op(mode, key, val));
        endfunction

        function void check_result(logic [VAL_W-1:0] rv, logic [STATUS_W-1:0] st,
                                   logic [OCC_W-1:0] occ);
            lookup_t exp_r;
            if (expected_lookups.size() == 0)
            begin
                flag($sformatf("unexpected result: read_value %0h status %0d occupancy %0d",
                               rv, st, occ));
                return;
            end
            exp_r = expected_lookups.pop_front();
            results_seen++;
            if (rv !== exp_r.read_value)
                flag($sformatf("result %0d read_value: expected %0h, got %0h",
                               results_seen, exp_r.read_value, rv));
            if (st !== exp_r.status)
                flag($sformatf("result %0d status: expected %0d, got %0d",
                               results_seen, exp_r.status, st));
            if (occ !== exp_r.occupancy)
                flag($sformatf("result %0d occupancy: expected %0d, got %0d",
                               results_seen, exp_r.occupancy, occ));
        endfunction

    endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sparse_array_assoc_table_unit
// Drives lookups, updates, appends and deletes through the request channel
// with bursty traffic and a stalling response side, moves max_index across
// its extremes over APB between phases, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

    import sai_pkg::*;
    import sai_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int POOL_SIZE      = 48;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_style_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sai_req_if req_ch ();
    sai_rsp_if rsp_ch ();

    sparse_table_scoreboard sb;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               burst_left;
    int               idle_cycles = 0;
    int               limit_writes;

    sparse_array_assoc_table_unit #(
        .CAPACITY (CAPACITY_DEF)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KEY_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return 32'd1;
        if (pick == 2)
            return '0;
        return $urandom();
    endfunction

    // Send one item; bursts of random length are separated by random gaps, some of them empty.
    task automatic issue(input logic m, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.index       <= k;
        req_ch.write_value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(m, k, v);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit is_write, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_MAX_INDEX;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Change max_index only once the table has returned every result.
    task automatic set_limit(input logic [KEY_W-1:0] value);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        wdata = {$urandom(), $urandom()};
        wdata[KEY_W-1:0] = value;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(negedge clk);
        apb_access(1'b1, wdata, rdata);
        sb.set_limit(value);
        limit_writes++;
        apb_access(1'b0, '0, rdata);
        if (rdata[KEY_W-1:0] !== value)
            sb.flag($sformatf("max_index readback: expected %0h, got %0h",
                              value, rdata[KEY_W-1:0]));
    endtask

    task automatic run_phase(input int n_items);
        logic [KEY_W-1:0] lim;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        logic [63:0]      span;
        int               pick;
        lim  = sb.limit;
        span = {7'b0, lim} + 64'd1;
        key_pool[0] = '0;
        key_pool[1] = lim;
        key_pool[2] = lim + 1'b1;
        key_pool[3] = '1;
        for (int i = 4; i < 12; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 63));
        for (int i = 12; i < 36; i++)
            key_pool[i] = KEY_W'({$urandom(), $urandom()} % span);
        for (int i = 36; i < POOL_SIZE; i++)
            key_pool[i] = rand_key();
        // fill run writes a nonzero value to every pool key, which can fill the table
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            v = rand_value();
            if (v == '0)
                v = 32'd1;
            issue(MODE_WRITE, key_pool[i], v);
        end
        for (int i = POOL_SIZE; i < n_items; i++)
        begin
            k = ($urandom_range(0, 99) < 10) ? rand_key()
                                               : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 35)
                issue(MODE_READ, k, $urandom());
            else if (pick < 55)
                issue(MODE_WRITE, k, '0);
            else
                issue(MODE_WRITE, k, rand_value());
        end
    endtask

    // response side stalls on its own schedule
    initial
    begin
        rx_style_e style;
        int        span;
        rsp_ch.ready = 1'b0;
        forever
        begin
            style = rx_style_e'($urandom_range(0, 3));
            span  = $urandom_range(20, 200);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                case (style)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= ((c % 24) >= 18);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.read_value, rsp_ch.status, rsp_ch.occupancy);
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] mid;
        logic [KEY_W-1:0] alt_hi;
        logic [KEY_W-1:0] alt_lo;
        sb                 = new();
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_READ;
        req_ch.index       = '0;
        req_ch.write_value = '0;
        burst_left         = 0;
        limit_writes       = 0;
        alt_hi             = {1'b1, {28{2'b01}}};
        alt_lo             = {1'b0, {28{2'b10}}};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under the reset limit
        issue(MODE_READ,  '0, '0);
        issue(MODE_WRITE, '0, 32'd1);
        issue(MODE_WRITE, '1, '1);                  // above limit
        issue(MODE_READ,  '1, '1);                  // read above limit is plain lookup
        issue(MODE_WRITE, MAX_INDEX_RESET, '1);     // right at the limit
        issue(MODE_WRITE, MAX_INDEX_RESET + 1'b1, 32'd5);
        issue(MODE_WRITE, '0, 32'hA5A5_A5A5);       // update in place
        issue(MODE_WRITE, 57'd5, '0);               // zero write, index absent
        issue(MODE_WRITE, 57'd7, 32'd3);
        issue(MODE_WRITE, '0, '0);                  // delete first slot, shift down
        issue(MODE_READ,  '0, '1);
        issue(MODE_READ,  MAX_INDEX_RESET, '0);
        issue(MODE_WRITE, 57'd7, '0);               // delete last slot
        issue(MODE_WRITE, alt_hi, 32'h5555_5555);
        issue(MODE_WRITE, alt_lo, 32'hAAAA_AAAA);
        issue(MODE_READ,  alt_hi, '0);
        issue(MODE_READ,  alt_lo, '0);
        issue(MODE_WRITE, alt_hi, '0);

        set_limit('1);
        run_phase(400);
        set_limit('0);
        run_phase(150);
        mid = rand_key() >> $urandom_range(1, 20);
        set_limit(mid);
        run_phase(400);
        set_limit(MAX_INDEX_RESET);
        run_phase(250);

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));

        $display("Covered %0d results: %0d reads, %0d deletes, %0d limit rejects, %0d full rejects",
                 sb.results_seen, sb.n_reads, sb.n_deletes, sb.n_limit_rejects,
                 sb.n_full_rejects);
        $display("max_index written %0d times (all ones, zero, mid, reset value); %0d mismatches",
                 limit_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/sai_pkg.sv
rtl/core/sai_if.sv
rtl/core/sparse_array_assoc_table_unit.sv
tb/sv/sai_tb_pkg.sv
tb/sv/testbench.sv
